@@ rtl/tcce_pkg.sv @@
`timescale 1ns / 1ps

package tcce_pkg;

    // Screen geometry and tab spacing
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_STOP   = 4;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    // Field widths
    localparam int ADDR_W = 11;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;
    localparam int TAB_W  = $clog2(TAB_STOP + 1);

    // Operation codes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Character codes with a control meaning
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'd32;

    // Cell contents after reset: space, light grey on black
    localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0720;

    typedef enum logic [10:0] {
        ST_CLEAR     = 11'b000_0000_0001,
        ST_IDLE      = 11'b000_0000_0010,
        ST_READ      = 11'b000_0000_0100,
        ST_BKSP      = 11'b000_0000_1000,
        ST_NEWLINE   = 11'b000_0001_0000,
        ST_TAB       = 11'b000_0010_0000,
        ST_CHAR      = 11'b000_0100_0000,
        ST_SCR_COPY  = 11'b000_1000_0000,
        ST_SCR_LAST  = 11'b001_0000_0000,
        ST_SCR_BLANK = 11'b010_0000_0000,
        ST_FINISH    = 11'b100_0000_0000
    } state_t;

    // Linear cell address of a row and column
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [ADDR_W:0] sum;
        sum = (ADDR_W+1)'(row) * (ADDR_W+1)'(COLUMNS) + (ADDR_W+1)'(col);
        return sum[ADDR_W-1:0];
    endfunction

endpackage

@@ rtl/text_console_char_engine.sv @@
`timescale 1ns / 1ps

// Text console character engine: an 80x25 screen store of 16-bit cells
// (attribute byte high, character byte low) plus a cursor.
// Command channel: drive op, char_code and cell_index with start high; the
// transaction is taken on the clock edge where start is high and busy is low.
// op = put interprets char_code (backspace, newline, tab or a printable
// byte); op = read fetches one cell at cell_index.
// Result channel: done pulses for exactly one cycle with cell_value (0 for a
// put) and the cursor after the transaction. The receiver cannot stall; the
// result is taken on the edge that ends the done cycle, and a new command can
// be taken in that same cycle.
// A tab writes spaces up to the next tab stop. A printable byte or tab that
// meets a pending wrap (cursor past the last column) first moves to the next
// row. A scroll copies the screen up one row through the single write port
// of the store, one cell per cycle with the read one row ahead, then writes
// the last copied cell and blanks the bottom row.
// Config channel: cfg_data is the color attribute; it is always ready and is
// written whenever cfg_valid is high. Write it only while idle.
// Reset: the cursor goes home, the color returns to 0x07, and a clearing pass
// writes blank 0x0720 to all 2000 cells with busy held high.

module text_console_char_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          op,
    input  logic [tcce_pkg::CHAR_W-1:0]   char_code,
    input  logic [tcce_pkg::ADDR_W-1:0]   cell_index,
    output logic                          done,
    output logic [tcce_pkg::CELL_W-1:0]   cell_value,
    output logic [tcce_pkg::ROW_W-1:0]    cursor_row,
    output logic [tcce_pkg::COL_W-1:0]    cursor_column,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tcce_pkg::ATTR_W-1:0]   cfg_data
);

    import tcce_pkg::*;

    // Sequencer and cursor state
    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ATTR_W-1:0]   color_reg;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic                done_reg, done_next;

    // Per-transaction payload
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic [TAB_W-1:0]    tab_cnt_reg, tab_cnt_next;
    logic                in_range_reg, in_range_next;
    logic [CELL_W-1:0]   cell_value_reg, cell_value_next;

    // Store port controls
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [CELL_W-1:0]   wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [CELL_W-1:0]   rd_data;

    logic                accept;
    logic [ROW_W-1:0]    bs_row;
    logic [COL_W-1:0]    bs_col;
    logic [CELL_W-1:0]   blank_cell;

    tcce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign busy          = (state_reg != ST_IDLE);
    assign accept        = start && !busy;
    assign cfg_ready     = 1'b1;
    assign done          = done_reg;
    assign cell_value    = cell_value_reg;
    assign cursor_row    = row_reg;
    assign cursor_column = col_reg;
    assign blank_cell    = {color_reg, CODE_SPACE};

    // Backspace target: step left, wrap to the end of the previous row,
    // hold at the home position
    always_comb
    begin
        bs_row = row_reg;
        bs_col = col_reg;
        if (col_reg != '0)
        begin
            bs_col = col_reg - 1'b1;
        end
        else if (row_reg != '0)
        begin
            bs_row = row_reg - 1'b1;
            bs_col = COL_W'(COLUMNS - 1);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        idx_next        = idx_reg;
        done_next       = 1'b0;
        char_next       = char_reg;
        tab_cnt_next    = tab_cnt_reg;
        in_range_next   = in_range_reg;
        cell_value_next = cell_value_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = blank_cell;
        rd_en           = 1'b0;
        rd_addr         = idx_reg + ADDR_W'(COLUMNS);

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_data  = BLANK_RESET;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    char_next = char_code;
                    if (op == OP_READ)
                    begin
                        rd_en         = 1'b1;
                        rd_addr       = cell_index;
                        in_range_next = (cell_index < ADDR_W'(CELL_COUNT));
                        state_next    = ST_READ;
                    end
                    else
                    begin
                        case (char_code)
                            CODE_BACKSPACE: state_next = ST_BKSP;
                            CODE_NEWLINE:   state_next = ST_NEWLINE;
                            CODE_TAB:
                            begin
                                tab_cnt_next = TAB_W'(TAB_STOP)
                                    - TAB_W'(col_reg % COL_W'(TAB_STOP));
                                state_next   = ST_TAB;
                            end
                            default:        state_next = ST_CHAR;
                        endcase
                    end
                end
            end

            ST_READ:
            begin
                cell_value_next = in_range_reg ? rd_data : '0;
                done_next       = 1'b1;
                state_next      = ST_IDLE;
            end

            ST_BKSP:
            begin
                row_next        = bs_row;
                col_next        = bs_col;
                wr_en           = 1'b1;
                wr_addr         = cell_addr(bs_row, bs_col);
                cell_value_next = '0;
                done_next       = 1'b1;
                state_next      = ST_IDLE;
            end

            ST_NEWLINE:
            begin
                col_next = '0;
                if (row_reg == ROW_W'(ROWS - 1))
                begin
                    idx_next   = '0;
                    ret_next   = ST_FINISH;
                    state_next = ST_SCR_COPY;
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = ST_FINISH;
                end
            end

            ST_TAB:
            begin
                // One space per pass; a pass that finds a pending wrap writes no space
                if (tab_cnt_reg == '0)
                begin
                    cell_value_next = '0;
                    done_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
                else if (col_reg >= COL_W'(COLUMNS))
                begin
                    col_next = '0;
                    if (row_reg == ROW_W'(ROWS - 1))
                    begin
                        idx_next   = '0;
                        ret_next   = ST_TAB;
                        state_next = ST_SCR_COPY;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    wr_en        = 1'b1;
                    wr_addr      = cell_addr(row_reg, col_reg);
                    col_next     = col_reg + 1'b1;
                    tab_cnt_next = tab_cnt_reg - 1'b1;
                end
            end

            ST_CHAR:
            begin
                if (col_reg >= COL_W'(COLUMNS))
                begin
                    col_next = '0;
                    if (row_reg == ROW_W'(ROWS - 1))
                    begin
                        idx_next   = '0;
                        ret_next   = ST_CHAR;
                        state_next = ST_SCR_COPY;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    wr_en           = 1'b1;
                    wr_addr         = cell_addr(row_reg, col_reg);
                    wr_data         = {color_reg, char_reg};
                    col_next        = col_reg + 1'b1;
                    cell_value_next = '0;
                    done_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_SCR_COPY:
            begin
                // Read one row ahead, write the cell read on the previous cycle
                rd_en    = 1'b1;
                wr_en    = (idx_reg != '0);
                wr_addr  = idx_reg - 1'b1;
                wr_data  = rd_data;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == ADDR_W'(CELL_COUNT - COLUMNS - 1))
                begin
                    state_next = ST_SCR_LAST;
                end
            end

            ST_SCR_LAST:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg - 1'b1;
                wr_data    = rd_data;
                state_next = ST_SCR_BLANK;
            end

            ST_SCR_BLANK:
            begin
                wr_en    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    idx_next   = '0;
                    state_next = ret_reg;
                end
            end

            ST_FINISH:
            begin
                cell_value_next = '0;
                done_next       = 1'b1;
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ret_reg   <= ST_FINISH;
            row_reg   <= '0;
            col_reg   <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
            color_reg <= ATTR_W'(BLANK_RESET >> CHAR_W);
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                color_reg <= cfg_data;
            end
        end
    end

    // Payload holds its value between transactions
    always_ff @(posedge clk)
    begin
        char_reg       <= char_next;
        tab_cnt_reg    <= tab_cnt_next;
        in_range_reg   <= in_range_next;
        cell_value_reg <= cell_value_next;
    end

endmodule

@@ rtl/tcce_ram.sv @@
`timescale 1ns / 1ps

module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
